// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkvc_update, lru_key_value_cache and lkvc_checker.
package lkvc_pkg;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Register word index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } res_t;

endpackage

// ===== sv/lkvc_update.sv =====
`timescale 1ns / 1ps
// Next-state and result logic for one cache item: key match, LRU rank update,
// eviction and free-slot pick. Depends on lkvc_pkg.
module lkvc_update
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned RW = $clog2(ENTRIES)
) (
  input  op_e                          op_i,
  input  logic [31:0]                  key_i,
  input  logic [4:0]                   cap_i,
  input  logic [ENTRIES-1:0]           valid_i,
  input  logic [ENTRIES-1:0][RW-1:0]   rank_i,
  input  logic [ENTRIES-1:0][31:0]     keys_i,
  input  logic [ENTRIES-1:0][31:0]     vals_i,
  output logic [ENTRIES-1:0]           valid_o,
  output logic [ENTRIES-1:0][RW-1:0]   rank_o,
  output logic [ENTRIES-1:0]           wr_sel_o,
  output res_t                         res_o
);

  localparam int unsigned CW = (RW + 1 > 5) ? RW + 1 : 5;
  localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);

  logic [CW-1:0]              eff_cap;
  logic [CW-1:0]              lim;
  logic [ENTRIES-1:0]         match;
  logic                       hit;
  logic [RW-1:0]              hit_rank;
  logic [31:0]                hit_val;
  logic [ENTRIES-1:0]         valid1;
  logic [ENTRIES-1:0][RW-1:0] rank1;
  logic [ENTRIES-1:0]         evict;
  logic [ENTRIES-1:0]         valid2;
  logic [ENTRIES-1:0]         free;
  logic [ENTRIES-1:0]         first_free;

  // Clamp capacity into 1..ENTRIES; entries ranked at lim or older go on a put
  always_comb begin
    eff_cap = CW'(cap_i);
    if (eff_cap == '0) begin
      eff_cap = CW'(1);
    end
    if (eff_cap > ENT_C) begin
      eff_cap = ENT_C;
    end
    lim = eff_cap - CW'(1);
  end

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_i[i] && (keys_i[i] == key_i);
      hit_rank = hit_rank | (rank_i[i] & {RW{match[i]}});
      hit_val  = hit_val | (vals_i[i] & {32{match[i]}});
    end
    hit = |match;
  end

  // Put: drop the matching entry and close its rank gap, then evict old ones
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid1[i] = valid_i[i] && !match[i];
      rank1[i]  = (hit && valid1[i] && (rank_i[i] > hit_rank)) ?
                  rank_i[i] - RW'(1) : rank_i[i];
      evict[i]  = valid1[i] && (CW'(rank1[i]) >= lim);
      valid2[i] = valid1[i] && !evict[i];
    end
    free       = ~valid2;
    first_free = free & (~free + ENTRIES'(1));
  end

  always_comb begin
    res_o.hit        = hit;
    res_o.read_value = '0;
    res_o.evicted    = 1'b0;
    valid_o          = valid_i;
    rank_o           = rank_i;
    wr_sel_o         = '0;
    case (op_i)
      OP_GET: begin
        res_o.read_value = hit_val;
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_o[i] = '0;
          end else if (valid_i[i] && (rank_i[i] < hit_rank)) begin
            rank_o[i] = rank_i[i] + RW'(1);
          end
        end
      end
      OP_PUT: begin
        res_o.evicted = |evict;
        wr_sel_o      = first_free;
        valid_o       = valid2 | first_free;
        for (int i = 0; i < ENTRIES; i++) begin
          if (first_free[i]) begin
            rank_o[i] = '0;
          end else if (valid2[i]) begin
            rank_o[i] = rank1[i] + RW'(1);
          end
        end
      end
      default: begin
        res_o.read_value = '0;
      end
    endcase
  end

endmodule

// ===== sv/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// Top level of the fully associative LRU key-value cache with APB config port.
// Depends on lkvc_pkg and lkvc_update.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+---------------------------------
//   command  | start_i, busy_o                 | opcode_i, key_i, value_i
//   result   | result_valid_o (one-cycle pulse)| hit_o, read_value_o, evicted_o
//   config   | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One item per cycle: busy_o stays low, so start_i may be high every cycle.
// An accepted item is registered in the input register, looked up against every
// entry in the following cycle, and its result is then held in the result
// register, which drives the result channel.
// The input register and result register sit around the combinational key
// compare and rank update.
// rst_ni clears valid marks, ranks and strobes; capacity returns to 16.
// Results cannot be stalled: take each one in the cycle its strobe is high.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  // result side
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [31:0] read_value_o,
  output logic        evicted_o,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RW = $clog2(ENTRIES);

  // Input register
  logic        in_vld_q;
  op_e         op_q;
  logic [31:0] key_q;
  logic [31:0] val_q;

  // Cache state: valid marks and ranks are control, keys/values are storage
  logic [ENTRIES-1:0]         valid_q, valid_d;
  logic [ENTRIES-1:0][RW-1:0] rank_q, rank_d;
  logic [ENTRIES-1:0][31:0]   keys_q;
  logic [ENTRIES-1:0][31:0]   vals_q;
  logic [ENTRIES-1:0]         wr_sel;

  logic [4:0] cap_q;

  // Result register
  logic res_vld_q;
  res_t res_q, res_d;

  logic accept;
  logic cfg_wr;

  // Every cycle is free for a new item
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, cap_q} : '0;

  lkvc_update #(
    .ENTRIES (ENTRIES)
  ) u_update (
    .op_i     (op_q),
    .key_i    (key_q),
    .cap_i    (cap_q),
    .valid_i  (valid_q),
    .rank_i   (rank_q),
    .keys_i   (keys_q),
    .vals_i   (vals_q),
    .valid_o  (valid_d),
    .rank_o   (rank_d),
    .wr_sel_o (wr_sel),
    .res_o    (res_d)
  );

  // Control: input strobe, valid marks, ranks, capacity, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      valid_q   <= '0;
      rank_q    <= '0;
      cap_q     <= CAPACITY_RESET;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      res_vld_q <= in_vld_q;
      if (in_vld_q) begin
        valid_q <= valid_d;
        rank_q  <= rank_d;
      end
      if (cfg_wr) begin
        cap_q <= pwdata[4:0];
      end
    end
  end

  // Payload: hold the command, store the new pair, register the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(opcode_i);
      key_q <= key_i;
      val_q <= value_i;
    end
    if (in_vld_q) begin
      res_q <= res_d;
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_sel[i]) begin
          keys_q[i] <= key_q;
          vals_q[i] <= val_q;
        end
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign hit_o          = res_q.hit;
  assign read_value_o   = res_q.read_value;
  assign evicted_o      = res_q.evicted;

endmodule

// ===== sv/lkvc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        opcode_i,
  input logic [31:0] key_i,
  input logic [31:0] value_i,
  input logic        result_valid_o,
  input logic        hit_o,
  input logic [31:0] read_value_o,
  input logic        evicted_o
);

  // Each accepted item is followed by its result strobe
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without an accepted item");

  // Only a put evicts
  a_evict_on_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_o) |-> ($past(opcode_i, 2) == OP_PUT))
    else $error("eviction reported on a get");

  // A get issued right after a put of the same key hits and reads that value
  a_put_then_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start_i && !busy_o && (opcode_i == OP_PUT)) && start_i && !busy_o &&
     (opcode_i == OP_GET) && (key_i == $past(key_i)))
    |=> ##1 (hit_o && (read_value_o == $past(value_i, 3))))
    else $error("get after put missed or returned a stale value");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .key_i          (key_i),
  .value_i        (value_i),
  .result_valid_o (result_valid_o),
  .hit_o          (hit_o),
  .read_value_o   (read_value_o),
  .evicted_o      (evicted_o)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: random and directed get/put items
// checked against a cycle-free LRU shadow of the cache. Depends on lkvc_pkg and the RTL.
module tb_top;
  import lkvc_pkg::*;

  localparam int SLOTS = 16;
  // Longest run of cycles with neither an item nor a result taken.
  localparam int STALL_LIMIT = 2000;
  // Cycles to let pass once nothing is outstanding, so the pipe is idle.
  localparam int SETTLE_CYCLES = 4;

  // Shadow of the cache contents. Each accepted item updates it at once and
  // queues the response the block must produce for it.
  class lru_shadow;
    logic [31:0] keys[SLOTS];
    logic [31:0] vals[SLOTS];
    bit          valid[SLOTS];
    int unsigned rank[SLOTS];
    int unsigned count;
    logic [4:0]  capacity;
    res_t        pending_responses[$];
    int unsigned mismatches;

    function new();
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        rank[i]  = 0;
      end
      count      = 0;
      capacity   = CAPACITY_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [4:0] c);
      capacity = c;
    endfunction

    function int unsigned usable_entries();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    function void note_access(op_e op, logic [31:0] key, logic [31:0] value);
      int   found;
      int   slot;
      int unsigned r;
      int unsigned lim;
      res_t resp;
      found = -1;
      slot  = -1;
      foreach (keys[i])
        if (found < 0 && valid[i] && keys[i] == key) found = i;
      resp.hit        = (found >= 0);
      resp.read_value = '0;
      resp.evicted    = 1'b0;
      if (op == OP_GET) begin
        if (found >= 0) begin
          r = rank[found];
          foreach (rank[i])
            if (valid[i] && rank[i] < r) rank[i]++;
          rank[found] = 0;
          resp.read_value = vals[found];
        end
      end else begin
        lim = usable_entries() - 1;
        // Pull a present key out first, closing the gap in the ranks.
        if (found >= 0) begin
          r = rank[found];
          valid[found] = 1'b0;
          if (count > 0) count--;
          foreach (rank[i])
            if (valid[i] && rank[i] > r) rank[i]--;
        end
        // Drop every entry that would not fit beside the new one.
        foreach (valid[i]) begin
          if (valid[i] && rank[i] >= lim) begin
            valid[i] = 1'b0;
            if (count > 0) count--;
            resp.evicted = 1'b1;
          end
        end
        foreach (valid[i]) begin
          if (valid[i]) rank[i]++;
          else if (slot < 0) slot = i;
        end
        if (slot >= 0) begin
          keys[slot]  = key;
          vals[slot]  = value;
          valid[slot] = 1'b1;
          rank[slot]  = 0;
          count++;
        end
      end
      pending_responses.push_back(resp);
    endfunction

    function void check_response(logic hit, logic [31:0] read_value, logic evicted);
      res_t want;
      if (pending_responses.size() == 0) begin
        $display("%0t: result with nothing outstanding: hit %0b read_value %08h evicted %0b",
                 $time, hit, read_value, evicted);
        mismatches++;
        return;
      end
      want = pending_responses.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
        mismatches++;
      end
      if (read_value !== want.read_value) begin
        $display("%0t: read_value expected %08h actual %08h", $time, want.read_value,
                 read_value);
        mismatches++;
      end
      if (evicted !== want.evicted) begin
        $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, evicted);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_responses.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [31:0] key_i;
  logic [31:0] value_i;
  logic        result_valid_o;
  logic        hit_o;
  logic [31:0] read_value_o;
  logic        evicted_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_shadow   shadow;
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned stall_cycles;
  logic [31:0] key_pool[24];

  always #5 clk_i = ~clk_i;

  lru_key_value_cache #(
    .ENTRIES(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Watch every edge: feed accepted items and register writes into the shadow,
  // check strobed results, and end the run if traffic stops for too long.
  // Values read here are the ones present before the edge, so the order of
  // processes within the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) shadow.note_access(op_e'(opcode_i), key_i, value_i);
      if (result_valid_o) shadow.check_response(hit_o, read_value_o, evicted_o);
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
        shadow.set_capacity(pwdata[4:0]);
      if ((start_i && !busy_o) || result_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one item and hold it until accepted. A random gap may come first,
  // its length set by idle_pct so that gaps land on every phase of the pipe.
  task automatic send_item(input op_e op, input logic [31:0] key, input logic [31:0] value);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i  <= 1'b1;
    opcode_i <= op;
    key_i    <= key;
    value_i  <= value;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Stop sending and hold until every queued response has come back, then
  // let the pipe settle so the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Two-phase register write; upper data bits are noise the block must ignore.
  task automatic write_capacity(input logic [4:0] c);
    logic [31:0] word;
    word      = $urandom();
    word[4:0] = c;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly keys from a pool a little larger than the capacity, so that gets
  // hit, puts overwrite and evictions happen; the rest are edge keys and noise.
  function automatic logic [31:0] pick_key(int unsigned pool_n);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return key_pool[$urandom_range(pool_n - 1)];
    if (r < 90) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    return $urandom();
  endfunction

  // One random phase at a given capacity setting. The sender idles in about
  // one cycle in five for the first third of the run, in four of five for
  // the second, and never for the last.
  task automatic run_phase(input logic [4:0] cap, input int unsigned n);
    int unsigned pool_n;
    op_e         op;
    drain();
    write_capacity(cap);
    pool_n = shadow.usable_entries() + 4;
    repeat (n) begin
      if (items_sent < 400) idle_pct = 20;
      else if (items_sent < 800) idle_pct = 79;
      else idle_pct = 0;
      op = $urandom_range(1) ? OP_PUT : OP_GET;
      send_item(op, pick_key(pool_n), $urandom());
    end
  endtask

  initial begin
    rst_ni   <= 1'b0;
    start_i  <= 1'b0;
    opcode_i <= OP_GET;
    key_i    <= '0;
    value_i  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    shadow       = new();
    idle_pct     = 0;
    items_sent   = 0;
    stall_cycles = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-cache miss, extreme keys and values, overwrite of a
    // present key, and a miss on a key never stored. Capacity is at reset.
    send_item(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    send_item(OP_PUT, 32'h0000_0000, 32'h8000_0000);
    send_item(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_item(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_GET, 32'h1234_5678, 32'h0000_0000);

    // Lower the capacity below the fill level: the next put drops several
    // entries in one step.
    drain();
    write_capacity(5'd2);
    send_item(OP_PUT, 32'h0000_0001, 32'h0000_0001);
    send_item(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0001, 32'h0000_0000);

    // Capacity zero acts as one: every put replaces the single entry.
    drain();
    write_capacity(5'd0);
    send_item(OP_PUT, 32'h0000_0002, 32'h0000_0002);
    send_item(OP_PUT, 32'h0000_0003, 32'h0000_0003);
    send_item(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_item(OP_GET, 32'h0000_0002, 32'h0000_0000);
    send_item(OP_PUT, 32'h0000_0003, 32'h0000_0004);

    // Random phases: saturated, minimum and mid capacities, with drops from
    // a full cache to a small one along the way.
    run_phase(5'd31, 150);
    run_phase(5'd1, 150);
    run_phase(5'd16, 150);
    run_phase(5'd0, 150);
    run_phase(5'd5, 150);
    run_phase(5'($urandom_range(2, 15)), 150);
    run_phase(5'd8, 150);
    run_phase(5'd2, 150);

    drain();
    repeat (10) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
